>>> hdl/adr_pkg.sv
// ----------------------------------------------------------------------------
// adr_pkg
// Shared types, constants and helpers for the decimating requantizer.
// ----------------------------------------------------------------------------
package adr_pkg;

    // sizes fixed by the sample and register formats
    localparam int MAX_DECIMATION = 4096;
    localparam int CHANNELS       = 2;
    localparam int RATE_W         = 29;
    localparam int QUANT_W        = 24;
    localparam int SUM_W          = 29;

    localparam logic [RATE_W-1:0]  RATE_ONE   = RATE_W'(65536);
    localparam logic [RATE_W-1:0]  RATE_MAX   = RATE_W'(MAX_DECIMATION * 65536);
    localparam logic [QUANT_W-1:0] QUANT_ONE  = QUANT_W'(256);
    localparam logic [QUANT_W-1:0] QUANT_MAX  = QUANT_W'(8388608);

    // divider sizes: long numerator for rate division, short for quantizer
    localparam int DIV_W       = 47;
    localparam int DIV_SHORT_W = 25;
    localparam int DEN_W       = 30;
    localparam int DIV_CNT_W   = 6;

    typedef enum logic [1:0] {
        CFG_RATE_STEP     = 2'd0,
        CFG_QUANT_STEP    = 2'd1,
        CFG_DITHER_ENABLE = 2'd2,
        CFG_CHANNEL_COUNT = 2'd3
    } cfg_index_e;

    typedef struct packed {
        logic signed [15:0] sample_left;
        logic signed [15:0] sample_right;
        logic               restart;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] out_left;
        logic signed [15:0] out_right;
    } out_item_t;

    typedef struct packed {
        logic start;
        logic long_mode;
    } div_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_DEC_MUL,
        ST_DEC_CARRY,
        ST_DEC_DIV,
        ST_DEC_WAIT,
        ST_QSEL,
        ST_Q_DIV,
        ST_Q_WAIT,
        ST_Q_MUL,
        ST_Q_OUT,
        ST_DONE
    } seq_state_t;

    // saturate a sign and magnitude to 16 bit signed
    function automatic logic [15:0] sat_mag(input logic neg, input logic [DIV_W-1:0] mag);
        logic [15:0] r;
        if (!neg)
        begin
            r = (mag > DIV_W'(32767)) ? 16'h7fff : mag[15:0];
        end
        else
        begin
            r = (mag >= DIV_W'(32768)) ? 16'h8000 : 16'(-mag[15:0]);
        end
        return r;
    endfunction

endpackage

>>> hdl/adr_div.sv
// ----------------------------------------------------------------------------
// adr_div
// Shared restoring divider, one quotient bit per cycle, long or short mode.
// ----------------------------------------------------------------------------
module adr_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  adr_pkg::div_cmd_t           cmd,
    input  logic [adr_pkg::DIV_W-1:0]   num,
    input  logic [adr_pkg::DEN_W-1:0]   den,
    output logic                        done,
    output logic [adr_pkg::DIV_W-1:0]   quo
);
    import adr_pkg::*;

    logic                 active_reg, active_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     num_reg, num_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DEN_W-1:0]     rem_reg, rem_next;
    logic [DEN_W-1:0]     den_reg, den_next;
    logic [DEN_W:0]       trial;

    // one shift and subtract step per cycle
    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        num_next    = num_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        den_next    = den_reg;
        trial       = {rem_reg, num_reg[DIV_W-1]};
        if (cmd.start)
        begin
            active_next = 1'b1;
            den_next    = den;
            rem_next    = '0;
            quo_next    = '0;
            if (cmd.long_mode)
            begin
                num_next = num;
                cnt_next = DIV_CNT_W'(DIV_W);
            end
            else
            begin
                num_next = {num[DIV_SHORT_W-1:0], (DIV_W-DIV_SHORT_W)'(0)};
                cnt_next = DIV_CNT_W'(DIV_SHORT_W);
            end
        end
        else if (active_reg)
        begin
            num_next = {num_reg[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = DEN_W'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

>>> hdl/audio_decimate_requantize_core.sv
// ----------------------------------------------------------------------------
// audio_decimate_requantize_core
// Stereo sample-rate reducer and requantizer with error feedback.
// ----------------------------------------------------------------------------
// usage
//   in_valid/in_stall carries one stereo frame per request; out_valid/out_stall
//   returns one degraded frame per request, in order. in_stall is high while a
//   frame is being worked on, so frames are taken one at a time.
//   with no decimation boundary and no bit reduction the output register loads
//   once the request has passed the prep and select states into done; each
//   active channel adds a multiply, a carry step and a 47-step divide when a
//   held value is recomputed, and a 25-step divide and a multiply for
//   requantization. the next request is taken once the block is back in idle,
//   and the frame time is set mostly by the one shared bit-serial divider.
//   the result sits in an output register; while out_stall is high the block
//   finishes the next frame and then waits until the register is taken.
//   configuration is written through cfg_we/cfg_index/cfg_data while idle.
//   reset (rst_n low) restores the default settings and clears the sums,
//   held values and feedback errors; a frame with restart set does the same
//   to the state before it is processed.
// ----------------------------------------------------------------------------
module audio_decimate_requantize_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  adr_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output adr_pkg::out_item_t            out_data,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [adr_pkg::RATE_W-1:0]    cfg_data
);
    import adr_pkg::*;

    // configuration
    logic [RATE_W-1:0]  rate_step_reg;
    logic [QUANT_W-1:0] quant_step_reg;
    logic               dither_reg;
    logic [1:0]         chan_count_reg;

    // sequencer and state
    seq_state_t               state_reg, state_next;
    logic                     ch_reg, ch_next;
    logic                     out_valid_reg, out_valid_next;
    out_item_t                out_data_reg, out_data_next;
    logic signed [15:0]       s_reg [2];
    logic signed [15:0]       s_next [2];
    logic                     restart_reg, restart_next;
    logic [RATE_W-1:0]        remainder_reg, remainder_next;
    logic signed [SUM_W-1:0]  sum_reg [2];
    logic signed [SUM_W-1:0]  sum_next [2];
    logic signed [15:0]       held_reg [2];
    logic signed [15:0]       held_next [2];
    logic signed [15:0]       err_reg [2];
    logic signed [15:0]       err_next [2];
    logic signed [15:0]       res_reg [2];
    logic signed [15:0]       res_next [2];
    logic [15:0]              ov_reg, ov_next;
    logic signed [41:0]       mul_reg, mul_next;
    logic signed [17:0]       carry_reg, carry_next;
    logic                     neg_reg, neg_next;
    logic signed [16:0]       k_reg, k_next;

    // divider hookup
    div_cmd_t            div_cmd;
    logic [DIV_W-1:0]    div_num;
    logic [DEN_W-1:0]    div_den;
    logic                div_done;
    logic [DIV_W-1:0]    div_quo;

    // effective settings
    logic [RATE_W-1:0]   eff_rs;
    logic [QUANT_W-1:0]  eff_qs;
    logic                decim, quant, two_ch;

    // scratch
    logic [RATE_W-1:0]        rem_fix;
    logic signed [RATE_W:0]   r_val;
    logic signed [15:0]       s_cur;
    logic signed [15:0]       h_cur;
    logic signed [SUM_W-1:0]  sum_base;
    logic signed [SUM_W:0]    diff;
    logic [29:0]              mag;
    logic [32:0]              pmag;
    logic [16:0]              cmag;
    logic [41:0]              qmag;
    logic [15:0]              hq;
    logic [15:0]              hmag;
    logic [RATE_W:0]          rem_sum;

    adr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // clamp settings into their working ranges
    always_comb
    begin
        if (rate_step_reg < RATE_ONE)
        begin
            eff_rs = RATE_ONE;
        end
        else if (rate_step_reg > RATE_MAX)
        begin
            eff_rs = RATE_MAX;
        end
        else
        begin
            eff_rs = rate_step_reg;
        end
        if (quant_step_reg < QUANT_ONE)
        begin
            eff_qs = QUANT_ONE;
        end
        else if (quant_step_reg > QUANT_MAX)
        begin
            eff_qs = QUANT_MAX;
        end
        else
        begin
            eff_qs = quant_step_reg;
        end
        decim  = eff_rs > RATE_ONE;
        quant  = eff_qs > QUANT_ONE;
        two_ch = chan_count_reg[1] && (CHANNELS == 2);
    end

    assign s_cur = ch_reg ? s_reg[1] : s_reg[0];
    assign h_cur = ch_reg ? held_reg[1] : held_reg[0];

    // sequencer: next state and datapath updates
    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        s_next         = s_reg;
        restart_next   = restart_reg;
        remainder_next = remainder_reg;
        sum_next       = sum_reg;
        held_next      = held_reg;
        err_next       = err_reg;
        res_next       = res_reg;
        ov_next        = ov_reg;
        mul_next       = mul_reg;
        carry_next     = carry_reg;
        neg_next       = neg_reg;
        k_next         = k_reg;
        div_cmd        = '0;
        div_num        = '0;
        div_den        = '0;
        rem_fix        = '0;
        r_val          = '0;
        sum_base       = '0;
        diff           = '0;
        mag            = '0;
        pmag           = '0;
        cmag           = '0;
        qmag           = '0;
        hq             = '0;
        hmag           = '0;
        rem_sum        = '0;

        // output register drains independently
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    s_next[0]    = in_data.sample_left;
                    s_next[1]    = in_data.sample_right;
                    restart_next = in_data.restart;
                    state_next   = ST_PREP;
                end
            end

            ST_PREP:
            begin
                // restart, remainder range fix and error clearing
                rem_fix = restart_reg ? eff_rs : remainder_reg;
                for (int c = 0; c < 2; c++)
                begin
                    if (restart_reg)
                    begin
                        held_next[c] = '0;
                        err_next[c]  = '0;
                    end
                    if (!dither_reg || !quant)
                    begin
                        err_next[c] = '0;
                    end
                end
                if (decim)
                begin
                    if (rem_fix == '0 || rem_fix > eff_rs)
                    begin
                        rem_fix = eff_rs;
                    end
                    for (int c = 0; c < 2; c++)
                    begin
                        sum_base = restart_reg ? SUM_W'(0) : sum_reg[c];
                        if (c == 0 || two_ch)
                        begin
                            sum_next[c] = SUM_W'(sum_base + s_reg[c]);
                        end
                        else
                        begin
                            sum_next[c] = sum_base;
                        end
                    end
                    r_val = $signed({1'b0, rem_fix}) - $signed({1'b0, RATE_ONE});
                    ch_next = 1'b0;
                    if (r_val <= 0)
                    begin
                        ov_next        = 16'(RATE_ONE - rem_fix);
                        remainder_next = rem_fix;
                        state_next     = ST_DEC_MUL;
                    end
                    else
                    begin
                        remainder_next = r_val[RATE_W-1:0];
                        state_next     = ST_QSEL;
                    end
                end
                else
                begin
                    // no decimation: samples go straight to the held values
                    remainder_next = RATE_ONE;
                    for (int c = 0; c < 2; c++)
                    begin
                        sum_next[c] = '0;
                        if (c == 0 || two_ch)
                        begin
                            held_next[c] = dither_reg ? 16'(s_reg[c] + err_next[c]) : s_reg[c];
                        end
                    end
                    state_next = ST_QSEL;
                end
            end

            ST_DEC_MUL:
            begin
                mul_next   = 42'(s_cur * $signed({1'b0, ov_reg}));
                state_next = ST_DEC_CARRY;
            end

            ST_DEC_CARRY:
            begin
                // carry share of the current sample, rounded
                pmag       = mul_reg[41] ? 33'(-mul_reg) : mul_reg[32:0];
                cmag       = 17'((pmag + 33'd32768) >> 16);
                carry_next = mul_reg[41] ? -$signed({1'b0, cmag}) : $signed({1'b0, cmag});
                state_next = ST_DEC_DIV;
            end

            ST_DEC_DIV:
            begin
                diff         = (ch_reg ? sum_reg[1] : sum_reg[0]) - carry_reg;
                neg_next     = diff[SUM_W];
                mag          = diff[SUM_W] ? 30'(-diff) : diff[29:0];
                div_cmd      = '{start: 1'b1, long_mode: 1'b1};
                div_num      = {mag, 17'd0} + DIV_W'(eff_rs);
                div_den      = {eff_rs, 1'b0};
                state_next   = ST_DEC_WAIT;
            end

            ST_DEC_WAIT:
            begin
                if (div_done)
                begin
                    hq = sat_mag(neg_reg, div_quo);
                    if (dither_reg)
                    begin
                        hq = hq + (ch_reg ? err_reg[1] : err_reg[0]);
                    end
                    held_next[ch_reg] = hq;
                    sum_next[ch_reg]  = SUM_W'(carry_reg);
                    if (!ch_reg && two_ch)
                    begin
                        ch_next    = 1'b1;
                        state_next = ST_DEC_MUL;
                    end
                    else
                    begin
                        rem_sum        = {1'b0, remainder_reg} + {1'b0, eff_rs}
                                         - {1'b0, RATE_ONE};
                        remainder_next = rem_sum[RATE_W-1:0];
                        state_next     = ST_QSEL;
                    end
                end
            end

            ST_QSEL:
            begin
                ch_next = 1'b0;
                if (quant)
                begin
                    res_next[0] = '0;
                    res_next[1] = '0;
                    state_next  = ST_Q_DIV;
                end
                else
                begin
                    res_next[0] = held_reg[0];
                    res_next[1] = two_ch ? held_reg[1] : 16'sd0;
                    state_next  = ST_DONE;
                end
            end

            ST_Q_DIV:
            begin
                hmag       = h_cur[15] ? 16'(-h_cur) : h_cur;
                neg_next   = h_cur[15];
                div_cmd    = '{start: 1'b1, long_mode: 1'b0};
                div_num    = DIV_W'({1'b0, hmag, 9'd0} + {1'b0, eff_qs});
                div_den    = DEN_W'({eff_qs, 1'b0});
                state_next = ST_Q_WAIT;
            end

            ST_Q_WAIT:
            begin
                if (div_done)
                begin
                    k_next     = neg_reg ? -$signed(div_quo[16:0]) : $signed(div_quo[16:0]);
                    state_next = ST_Q_MUL;
                end
            end

            ST_Q_MUL:
            begin
                mul_next   = 42'(k_reg * $signed({1'b0, eff_qs}));
                state_next = ST_Q_OUT;
            end

            ST_Q_OUT:
            begin
                qmag = mul_reg[41] ? 42'(-mul_reg) : mul_reg;
                hq   = sat_mag(mul_reg[41], DIV_W'((qmag + 42'd128) >> 8));
                res_next[ch_reg] = hq;
                if (dither_reg)
                begin
                    err_next[ch_reg] = 16'(h_cur - $signed(hq));
                end
                if (!ch_reg && two_ch)
                begin
                    ch_next    = 1'b1;
                    state_next = ST_Q_DIV;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next         = 1'b1;
                    out_data_next.out_left  = res_reg[0];
                    out_data_next.out_right = res_reg[1];
                    state_next             = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_step_reg  <= RATE_ONE;
            quant_step_reg <= QUANT_ONE;
            dither_reg     <= 1'b1;
            chan_count_reg <= 2'd2;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_e'(cfg_index))
                CFG_RATE_STEP:     rate_step_reg  <= cfg_data;
                CFG_QUANT_STEP:    quant_step_reg <= cfg_data[QUANT_W-1:0];
                CFG_DITHER_ENABLE: dither_reg     <= cfg_data[0];
                CFG_CHANNEL_COUNT: chan_count_reg <= cfg_data[1:0];
                default:           dither_reg     <= dither_reg;
            endcase
        end
    end

    // sequencer and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ch_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            remainder_reg <= RATE_ONE;
            for (int c = 0; c < 2; c++)
            begin
                sum_reg[c]  <= '0;
                held_reg[c] <= '0;
                err_reg[c]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            out_valid_reg <= out_valid_next;
            remainder_reg <= remainder_next;
            sum_reg       <= sum_next;
            held_reg      <= held_next;
            err_reg       <= err_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        s_reg        <= s_next;
        restart_reg  <= restart_next;
        res_reg      <= res_next;
        ov_reg       <= ov_next;
        mul_reg      <= mul_next;
        carry_reg    <= carry_next;
        neg_reg      <= neg_next;
        k_reg        <= k_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
